>>> hw/rtl/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared codes, widths and types of the voxel face cull block.
// ----------------------------------------------------------------------------
package vfc_pkg;

  // fixed port widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 4;
  localparam int FACE_W = 3;
  localparam int VID_W  = 16;
  localparam int FACES  = 6;

  // command codes on the input port
  localparam logic [CMD_W-1:0] CMD_WR_VOXEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_BOUND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

  // face numbering, also bit positions of face masks
  localparam int FACE_FRONT  = 0;  // -z
  localparam int FACE_BACK   = 1;  // +z
  localparam int FACE_LEFT   = 2;  // -x
  localparam int FACE_RIGHT  = 3;  // +x
  localparam int FACE_TOP    = 4;  // +y
  localparam int FACE_BOTTOM = 5;  // -y

  // depth of the result queue
  localparam int RES_DEPTH = 2;
  // depth of the queue between front and back
  localparam int OP_DEPTH  = 4;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_WR_VOXEL  = 2'd0,
    OP_WR_BOUND  = 2'd1,
    OP_QUERY     = 2'd2,
    OP_QUERY_OUT = 2'd3
  } op_kind_e;

  // one result item
  typedef struct packed {
    logic [VID_W-1:0] block_id;
    logic [FACES-1:0] face_mask;
    logic             visible;
  } res_t;

endpackage

>>> hw/rtl/vfc_fifo.sv
// ----------------------------------------------------------------------------
// vfc_fifo
// Small register queue with occupancy count, used between front and back
// and in front of the result ports.
// ----------------------------------------------------------------------------
module vfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic [CNTW-1:0]  count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/vfc_front.sv
// ----------------------------------------------------------------------------
// vfc_front
// Decodes an input item, drops writes that do nothing and empty commands, and marks for a
// query which of its six neighbours lie inside the chunk.
// ----------------------------------------------------------------------------
module vfc_front #(
  parameter int CHUNK_EDGE = 16,
  parameter int ID_BITS    = 16,
  localparam int CW        = $clog2(CHUNK_EDGE),
  localparam int OP_W      = $bits(vfc_pkg::op_kind_e) + 3 * CW + vfc_pkg::FACE_W
                             + ID_BITS + vfc_pkg::FACES
) (
  input  logic [vfc_pkg::CMD_W-1:0]  command_i,
  input  logic [vfc_pkg::POS_W-1:0]  pos_x_i,
  input  logic [vfc_pkg::POS_W-1:0]  pos_y_i,
  input  logic [vfc_pkg::POS_W-1:0]  pos_z_i,
  input  logic [vfc_pkg::FACE_W-1:0] face_sel_i,
  input  logic [vfc_pkg::VID_W-1:0]  voxel_id_i,
  output logic                       keep_o,
  output logic [OP_W-1:0]            op_o
);

  typedef struct packed {
    vfc_pkg::op_kind_e          kind;
    logic [CW-1:0]              x;
    logic [CW-1:0]              y;
    logic [CW-1:0]              z;
    logic [vfc_pkg::FACE_W-1:0] face;
    logic [ID_BITS-1:0]         id;
    logic [vfc_pkg::FACES-1:0]  nb_in;
  } op_t;

  op_t  op;
  logic in_range;
  logic face_ok;

  assign in_range = (int'(pos_x_i) < CHUNK_EDGE) && (int'(pos_y_i) < CHUNK_EDGE) &&
                    (int'(pos_z_i) < CHUNK_EDGE);
  assign face_ok  = int'(face_sel_i) < vfc_pkg::FACES;

  // classify the item
  always_comb begin
    op      = '0;
    keep_o  = 1'b0;
    op.x    = CW'(pos_x_i);
    op.y    = CW'(pos_y_i);
    op.z    = CW'(pos_z_i);
    op.face = face_sel_i;
    op.id   = ID_BITS'(voxel_id_i);
    // neighbours that stay inside the chunk
    op.nb_in[vfc_pkg::FACE_FRONT]  = (pos_z_i != '0);
    op.nb_in[vfc_pkg::FACE_BACK]   = (int'(pos_z_i) < CHUNK_EDGE - 1);
    op.nb_in[vfc_pkg::FACE_LEFT]   = (pos_x_i != '0);
    op.nb_in[vfc_pkg::FACE_RIGHT]  = (int'(pos_x_i) < CHUNK_EDGE - 1);
    op.nb_in[vfc_pkg::FACE_TOP]    = (int'(pos_y_i) < CHUNK_EDGE - 1);
    op.nb_in[vfc_pkg::FACE_BOTTOM] = (pos_y_i != '0);
    unique case (command_i)
      vfc_pkg::CMD_WR_VOXEL: begin
        op.kind = vfc_pkg::OP_WR_VOXEL;
        keep_o  = in_range;
      end
      vfc_pkg::CMD_WR_BOUND: begin
        op.kind = vfc_pkg::OP_WR_BOUND;
        keep_o  = in_range && face_ok;
      end
      vfc_pkg::CMD_QUERY: begin
        op.kind = in_range ? vfc_pkg::OP_QUERY : vfc_pkg::OP_QUERY_OUT;
        keep_o  = 1'b1;
      end
      vfc_pkg::CMD_NONE: begin
        keep_o  = 1'b0;
      end
      default: begin
        keep_o  = 1'b0;
      end
    endcase
  end

  assign op_o = op;

endmodule

>>> hw/rtl/vfc_back.sv
// ----------------------------------------------------------------------------
// vfc_back
// Carries out queued operations: writes the banked chunk store and the
// boundary layers, and answers queries in two read phases.
// ----------------------------------------------------------------------------
module vfc_back #(
  parameter int CHUNK_EDGE = 16,
  parameter int ID_BITS    = 16,
  localparam int CW        = $clog2(CHUNK_EDGE),
  localparam int OP_W      = $bits(vfc_pkg::op_kind_e) + 3 * CW + vfc_pkg::FACE_W
                             + ID_BITS + vfc_pkg::FACES,
  localparam int RCW       = $clog2(vfc_pkg::RES_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [vfc_pkg::FACES-1:0]  cfg_wdata_i,
  // operation queue
  input  logic                       op_valid_i,
  input  logic [OP_W-1:0]            op_i,
  output logic                       op_pop_o,
  // result queue
  input  logic [RCW-1:0]             res_count_i,
  output logic                       res_push_o,
  output vfc_pkg::res_t              res_o
);

  // chunk bank address: coordinates without their low bit
  localparam int CW3 = 3 * CW;
  localparam int AW  = (CW > 1) ? 3 * (CW - 1) : 1;
  // boundary layer address: two in-face coordinates
  localparam int LW  = 2 * CW;
  localparam int BANKS = 8;

  typedef struct packed {
    vfc_pkg::op_kind_e          kind;
    logic [CW-1:0]              x;
    logic [CW-1:0]              y;
    logic [CW-1:0]              z;
    logic [vfc_pkg::FACE_W-1:0] face;
    logic [ID_BITS-1:0]         id;
    logic [vfc_pkg::FACES-1:0]  nb_in;
  } op_t;

  typedef enum logic [1:0] {
    BK_ISSUE = 2'b01,
    BK_PLUS  = 2'b10
  } bk_state_e;

  function automatic logic [AW-1:0] bank_addr(logic [CW-1:0] x, logic [CW-1:0] y,
                                               logic [CW-1:0] z);
    logic [CW3-1:0] full;
    full = (CW3'(z >> 1) << (2 * (CW - 1))) | (CW3'(y >> 1) << (CW - 1)) |
           CW3'(x >> 1);
    return AW'(full);
  endfunction

  op_t                       head;
  op_t                       cur_q, cur_d;
  bk_state_e                 state_q, state_d;
  logic [1:0]                pend_q, pend_d;
  logic                      comb_q;
  logic [vfc_pkg::FACES-1:0] present_q;

  logic                      issue_a;
  logic                      credit;

  // read side
  logic [CW-1:0]             rx, ry, rz;
  logic [CW-1:0]             nx, ny, nz;
  logic [2:0]                rbank;
  logic [AW-1:0]             a_ctr, a_x, a_y, a_z;
  logic [AW-1:0]             bank_raddr [BANKS];
  logic [ID_BITS-1:0]        bank_rd [BANKS];
  logic [LW-1:0]             lay_yx, lay_zy, lay_zx;
  logic [LW-1:0]             bnd_raddr [vfc_pkg::FACES];
  logic [vfc_pkg::FACES-1:0] bnd_rd;

  // write side
  logic                      chk_we;
  logic [2:0]                chk_wbank;
  logic [AW-1:0]             chk_waddr;
  logic                      bnd_we;
  logic [LW-1:0]             bnd_waddr;
  logic                      bnd_wbit;

  // held results of the first read phase
  logic [ID_BITS-1:0]        ctr_q;
  logic                      xm_q, ym_q, zm_q;
  logic [2:0]                cbank;
  logic                      xp, yp, zp;
  logic [vfc_pkg::FACES-1:0] chunk_solid;
  logic [vfc_pkg::FACES-1:0] solid;

  assign head   = op_t'(op_i);
  assign credit = ((RCW+1)'(res_count_i) + (RCW+1)'(pend_q)) <
                  (RCW+1)'(vfc_pkg::RES_DEPTH);

  // sequencer
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    op_pop_o = 1'b0;
    issue_a  = 1'b0;
    chk_we   = 1'b0;
    bnd_we   = 1'b0;
    unique case (state_q)
      BK_ISSUE: begin
        if (op_valid_i) begin
          unique case (head.kind)
            vfc_pkg::OP_WR_VOXEL: begin
              chk_we   = 1'b1;
              op_pop_o = 1'b1;
            end
            vfc_pkg::OP_WR_BOUND: begin
              bnd_we   = 1'b1;
              op_pop_o = 1'b1;
            end
            vfc_pkg::OP_QUERY, vfc_pkg::OP_QUERY_OUT: begin
              if (credit) begin
                issue_a  = 1'b1;
                op_pop_o = 1'b1;
                cur_d    = head;
                state_d  = BK_PLUS;
              end
            end
            default: begin
              op_pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_PLUS: begin
        state_d = BK_ISSUE;
      end
      default: begin
        state_d = BK_ISSUE;
      end
    endcase
  end

  // outstanding query count
  always_comb begin
    pend_d = pend_q;
    if (issue_a && !comb_q) begin
      pend_d = pend_q + 1'b1;
    end else if (!issue_a && comb_q) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_ISSUE;
      pend_q    <= '0;
      comb_q    <= 1'b0;
      present_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      comb_q  <= (state_q == BK_PLUS);
      if (cfg_we_i) begin
        present_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // chunk read addresses: minus neighbours first, plus neighbours second
  assign rx    = (state_q == BK_PLUS) ? cur_q.x : head.x;
  assign ry    = (state_q == BK_PLUS) ? cur_q.y : head.y;
  assign rz    = (state_q == BK_PLUS) ? cur_q.z : head.z;
  assign nx    = (state_q == BK_PLUS) ? rx + 1'b1 : rx - 1'b1;
  assign ny    = (state_q == BK_PLUS) ? ry + 1'b1 : ry - 1'b1;
  assign nz    = (state_q == BK_PLUS) ? rz + 1'b1 : rz - 1'b1;
  assign rbank = {rz[0], ry[0], rx[0]};
  assign a_ctr = bank_addr(rx, ry, rz);
  assign a_x   = bank_addr(nx, ry, rz);
  assign a_y   = bank_addr(rx, ny, rz);
  assign a_z   = bank_addr(rx, ry, nz);

  // each bank serves the center or one axis pair
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      unique case (3'(b) ^ rbank)
        3'b001:  bank_raddr[b] = a_x;
        3'b010:  bank_raddr[b] = a_y;
        3'b100:  bank_raddr[b] = a_z;
        default: bank_raddr[b] = a_ctr;
      endcase
    end
  end

  // chunk write address
  assign chk_wbank = {head.z[0], head.y[0], head.x[0]};
  assign chk_waddr = bank_addr(head.x, head.y, head.z);

  // chunk store, eight parity banks
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [ID_BITS-1:0] mem [2**AW];
    logic [ID_BITS-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (chk_we && (chk_wbank == 3'(b))) begin
        mem[chk_waddr] <= head.id;
      end
      rd_q <= mem[bank_raddr[b]];
    end
    assign bank_rd[b] = rd_q;
  end

  // boundary layer addresses, read during the second phase
  assign lay_yx = {cur_q.y, cur_q.x};
  assign lay_zy = {cur_q.z, cur_q.y};
  assign lay_zx = {cur_q.z, cur_q.x};

  always_comb begin
    for (int f = 0; f < vfc_pkg::FACES; f++) begin
      if (f < 2) begin
        bnd_raddr[f] = lay_yx;
      end else if (f < 4) begin
        bnd_raddr[f] = lay_zy;
      end else begin
        bnd_raddr[f] = lay_zx;
      end
    end
  end

  // boundary write address
  always_comb begin
    priority if (int'(head.face) < 2) begin
      bnd_waddr = {head.y, head.x};
    end else if (int'(head.face) < 4) begin
      bnd_waddr = {head.z, head.y};
    end else begin
      bnd_waddr = {head.z, head.x};
    end
  end
  assign bnd_wbit = (head.id != '0);

  // boundary store, one layer per face
  for (genvar f = 0; f < vfc_pkg::FACES; f++) begin : g_layer
    logic mem [2**LW];
    logic rd_q;
    always_ff @(posedge clk_i) begin
      if (bnd_we && (head.face == vfc_pkg::FACE_W'(f))) begin
        mem[bnd_waddr] <= bnd_wbit;
      end
      rd_q <= mem[bnd_raddr[f]];
    end
    assign bnd_rd[f] = rd_q;
  end

  // hold center id and minus neighbours
  assign cbank = {cur_q.z[0], cur_q.y[0], cur_q.x[0]};

  always_ff @(posedge clk_i) begin
    if (state_q == BK_PLUS) begin
      ctr_q <= bank_rd[cbank];
      xm_q  <= (bank_rd[cbank ^ 3'b001] != '0);
      ym_q  <= (bank_rd[cbank ^ 3'b010] != '0);
      zm_q  <= (bank_rd[cbank ^ 3'b100] != '0);
    end
  end

  // combine into a result
  assign xp = (bank_rd[cbank ^ 3'b001] != '0);
  assign yp = (bank_rd[cbank ^ 3'b010] != '0);
  assign zp = (bank_rd[cbank ^ 3'b100] != '0);

  always_comb begin
    chunk_solid[vfc_pkg::FACE_FRONT]  = zm_q;
    chunk_solid[vfc_pkg::FACE_BACK]   = zp;
    chunk_solid[vfc_pkg::FACE_LEFT]   = xm_q;
    chunk_solid[vfc_pkg::FACE_RIGHT]  = xp;
    chunk_solid[vfc_pkg::FACE_TOP]    = yp;
    chunk_solid[vfc_pkg::FACE_BOTTOM] = ym_q;
    for (int f = 0; f < vfc_pkg::FACES; f++) begin
      solid[f] = cur_q.nb_in[f] ? chunk_solid[f] : (present_q[f] && bnd_rd[f]);
    end
  end

  always_comb begin
    res_o = '0;
    if (cur_q.kind == vfc_pkg::OP_QUERY) begin
      res_o.block_id  = 16'(ctr_q);
      res_o.face_mask = ~solid;
      res_o.visible   = (ctr_q != '0) && (solid != '1);
    end
  end

  assign res_push_o = comb_q;

endmodule

>>> hw/rtl/voxel_face_cull_core.sv
// ----------------------------------------------------------------------------
// voxel_face_cull_core
// Voxel chunk store with hidden-face culling queries.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | accepted when
//  ----------+-------------------------------------------+--------------------
//  request   | push, full, command/pos/face_sel/voxel_id | push && !full
//  result    | pop, empty, block_id/face_mask/visible    | pop && !empty
//  config    | cfg_we_i, cfg_wdata_i (neighbor_present)  | cfg_we_i
//
// A write request is carried out in the issue state alone, a query in the issue and plus states:
// its seven chunk reads share eight parity banks, center and minus
// neighbours in the first read phase, plus neighbours in the second.
// A query result enters the result queue in the cycle after its issue ends.
// Reset is asynchronous and clears control state only; the stores are not
// cleared. A 4-entry request queue lets the input run ahead; the back end
// issues a query only when the 2-entry result queue has a free slot.
// ----------------------------------------------------------------------------
module voxel_face_cull_core #(
  parameter int CHUNK_EDGE = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [vfc_pkg::FACES-1:0]  cfg_wdata_i,
  // request side
  input  logic                       push,
  output logic                       full,
  input  logic [vfc_pkg::CMD_W-1:0]  command_i,
  input  logic [vfc_pkg::POS_W-1:0]  pos_x_i,
  input  logic [vfc_pkg::POS_W-1:0]  pos_y_i,
  input  logic [vfc_pkg::POS_W-1:0]  pos_z_i,
  input  logic [vfc_pkg::FACE_W-1:0] face_sel_i,
  input  logic [vfc_pkg::VID_W-1:0]  voxel_id_i,
  // result side
  input  logic                       pop,
  output logic                       empty,
  output logic [vfc_pkg::VID_W-1:0]  block_id_o,
  output logic [vfc_pkg::FACES-1:0]  face_mask_o,
  output logic                       visible_o
);

  localparam int CW   = $clog2(CHUNK_EDGE);
  localparam int OP_W = $bits(vfc_pkg::op_kind_e) + 3 * CW + vfc_pkg::FACE_W
                        + ID_BITS + vfc_pkg::FACES;
  localparam int RW   = $bits(vfc_pkg::res_t);
  localparam int RCW  = $clog2(vfc_pkg::RES_DEPTH + 1);

  logic               keep;
  logic [OP_W-1:0]    front_op;
  logic               op_full;
  logic               op_empty;
  logic [OP_W-1:0]    op_head;
  logic               op_pop;
  logic               res_push;
  vfc_pkg::res_t      res_in;
  logic [RW-1:0]      res_head;
  logic [RCW-1:0]     res_count;
  vfc_pkg::res_t      res_out;

  // classify requests
  vfc_front #(
    .CHUNK_EDGE (CHUNK_EDGE),
    .ID_BITS    (ID_BITS)
  ) u_front (
    .command_i  (command_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .face_sel_i (face_sel_i),
    .voxel_id_i (voxel_id_i),
    .keep_o     (keep),
    .op_o       (front_op)
  );

  assign full = op_full;

  // queue between front and back
  vfc_fifo #(
    .WIDTH (OP_W),
    .DEPTH (vfc_pkg::OP_DEPTH)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && keep),
    .wdata_i (front_op),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .rdata_o (op_head),
    .empty_o (op_empty),
    .count_o ()
  );

  // execute operations
  vfc_back #(
    .CHUNK_EDGE (CHUNK_EDGE),
    .ID_BITS    (ID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_valid_i  (!op_empty),
    .op_i        (op_head),
    .op_pop_o    (op_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue
  vfc_fifo #(
    .WIDTH (RW),
    .DEPTH (vfc_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign res_out     = vfc_pkg::res_t'(res_head);
  assign block_id_o  = res_out.block_id;
  assign face_mask_o = res_out.face_mask;
  assign visible_o   = res_out.visible;

endmodule

>>> sim/voxel_face_cull_core_test.sv
// ----------------------------------------------------------------------------
// voxel_face_cull_core_test
// Drives chunk and boundary writes and voxel queries into the face cull core
// and checks every result against a software copy of the chunk.
// Queries are only issued once the voxel, its in-chunk neighbours and the
// boundary cells beside it hold known values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// software copy of the chunk; predicts id, exposed faces and visibility
class chunk_mirror #(int EDGE = 16);

  logic [vfc_pkg::VID_W-1:0] voxels [EDGE*EDGE*EDGE];
  bit                        voxel_known [EDGE*EDGE*EDGE];
  bit                        border [vfc_pkg::FACES*EDGE*EDGE];
  bit                        border_known [vfc_pkg::FACES*EDGE*EDGE];
  bit [vfc_pkg::FACES-1:0]   present = '0;
  vfc_pkg::res_t             answers_due [$];
  int                        errors = 0;

  function int cell_of(int x, int y, int z);
    return x + y * EDGE + z * EDGE * EDGE;
  endfunction

  // boundary cell beside the voxel, in-face coordinates depend on the face
  function int slot_of(int face, int x, int y, int z);
    int a, b;
    if (face < 2) begin
      a = y;
      b = x;
    end else if (face < 4) begin
      a = z;
      b = y;
    end else begin
      a = z;
      b = x;
    end
    return face * EDGE * EDGE + a * EDGE + b;
  endfunction

  // neighbour coordinate across one face; returns whether it is in the chunk
  function bit step_to(int face, int x, int y, int z,
                       output int nx, output int ny, output int nz);
    nx = x;
    ny = y;
    nz = z;
    case (face)
      vfc_pkg::FACE_FRONT:  nz = z - 1;
      vfc_pkg::FACE_BACK:   nz = z + 1;
      vfc_pkg::FACE_LEFT:   nx = x - 1;
      vfc_pkg::FACE_RIGHT:  nx = x + 1;
      vfc_pkg::FACE_TOP:    ny = y + 1;
      default:              ny = y - 1;
    endcase
    return nx >= 0 && nx < EDGE && ny >= 0 && ny < EDGE && nz >= 0 && nz < EDGE;
  endfunction

  function bit side_solid(int face, int x, int y, int z);
    int nx, ny, nz;
    if (step_to(face, x, y, z, nx, ny, nz))
      return voxels[cell_of(nx, ny, nz)] != '0;
    if (!present[face])
      return 1'b0;
    return border[slot_of(face, x, y, z)];
  endfunction

  function int outstanding();
    return answers_due.size();
  endfunction

  // accepted request: update the copy, queue the answer of a query
  function void apply_request(logic [vfc_pkg::CMD_W-1:0] cmd, int x, int y, int z,
                              int face, logic [vfc_pkg::VID_W-1:0] id);
    vfc_pkg::res_t want;
    case (cmd)
      vfc_pkg::CMD_WR_VOXEL: begin
        voxels[cell_of(x, y, z)] = id;
        voxel_known[cell_of(x, y, z)] = 1'b1;
      end
      vfc_pkg::CMD_WR_BOUND: begin
        if (face < vfc_pkg::FACES) begin
          border[slot_of(face, x, y, z)] = (id != '0);
          border_known[slot_of(face, x, y, z)] = 1'b1;
        end
      end
      vfc_pkg::CMD_QUERY: begin
        want.block_id = voxels[cell_of(x, y, z)];
        want.face_mask = '0;
        for (int f = 0; f < vfc_pkg::FACES; f++)
          if (!side_solid(f, x, y, z))
            want.face_mask[f] = 1'b1;
        want.visible = (want.block_id != '0) && (want.face_mask != '0);
        answers_due.push_back(want);
      end
      default: ;
    endcase
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task compare_result(logic [vfc_pkg::VID_W-1:0] id, logic [vfc_pkg::FACES-1:0] mask,
                      logic vis);
    vfc_pkg::res_t want;
    if (answers_due.size() == 0) begin
      report($sformatf("result with no query waiting: id %h mask %b vis %b",
                       id, mask, vis));
      return;
    end
    want = answers_due.pop_front();
    if (id !== want.block_id)
      report($sformatf("block_id %h, expected %h", id, want.block_id));
    if (mask !== want.face_mask)
      report($sformatf("face_mask %b, expected %b (id %h)", mask, want.face_mask,
                       want.block_id));
    if (vis !== want.visible)
      report($sformatf("visible %b, expected %b (id %h)", vis, want.visible,
                       want.block_id));
  endtask

endclass

module voxel_face_cull_core_test;

  localparam int CHUNK_EDGE  = 16;
  localparam int DRAIN       = 24;
  localparam int PHASE_ITEMS = 175;
  localparam int CYCLE_LIMIT = 400000;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [vfc_pkg::FACES-1:0]  cfg_wdata_i;
  logic                       push;
  logic                       full;
  logic [vfc_pkg::CMD_W-1:0]  command_i;
  logic [vfc_pkg::POS_W-1:0]  pos_x_i;
  logic [vfc_pkg::POS_W-1:0]  pos_y_i;
  logic [vfc_pkg::POS_W-1:0]  pos_z_i;
  logic [vfc_pkg::FACE_W-1:0] face_sel_i;
  logic [vfc_pkg::VID_W-1:0]  voxel_id_i;
  logic                       pop;
  logic                       empty;
  logic [vfc_pkg::VID_W-1:0]  block_id_o;
  logic [vfc_pkg::FACES-1:0]  face_mask_o;
  logic                       visible_o;

  chunk_mirror #(CHUNK_EDGE) mirror;
  int          counted = 0;
  bit          rush_in = 1'b0;
  bit          rush_out = 1'b0;
  int unsigned cycles = 0;

  voxel_face_cull_core #(
    .CHUNK_EDGE(CHUNK_EDGE),
    .ID_BITS   (16)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .command_i  (command_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .face_sel_i (face_sel_i),
    .voxel_id_i (voxel_id_i),
    .pop        (pop),
    .empty      (empty),
    .block_id_o (block_id_o),
    .face_mask_o(face_mask_o),
    .visible_o  (visible_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one request: optional gap, then hold push until accepted
  task automatic send_item(logic [vfc_pkg::CMD_W-1:0] cmd, int x, int y, int z,
                           int face, logic [vfc_pkg::VID_W-1:0] id);
    int gap;
    if ($urandom_range(0, 39) == 0)
      rush_in = !rush_in;
    gap = rush_in ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push       <= 1'b1;
    command_i  <= cmd;
    pos_x_i    <= x[vfc_pkg::POS_W-1:0];
    pos_y_i    <= y[vfc_pkg::POS_W-1:0];
    pos_z_i    <= z[vfc_pkg::POS_W-1:0];
    face_sel_i <= face[vfc_pkg::FACE_W-1:0];
    voxel_id_i <= id;
    do @(posedge clk_i); while (full !== 1'b0);
    mirror.apply_request(cmd, x, y, z, face, id);
    if (!(cmd == vfc_pkg::CMD_NONE ||
          (cmd == vfc_pkg::CMD_WR_BOUND && face >= vfc_pkg::FACES)))
      counted++;
  endtask

  // ids cluster on air and the top value
  function automatic logic [vfc_pkg::VID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return '0;
    if (r == 3)
      return '1;
    return vfc_pkg::VID_W'($urandom_range(1, 65535));
  endfunction

  // coordinates cluster near both chunk walls so neighbourhoods fill up
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return $urandom_range(0, 2);
    if (r < 8)
      return $urandom_range(CHUNK_EDGE - 3, CHUNK_EDGE - 1);
    return $urandom_range(0, CHUNK_EDGE - 1);
  endfunction

  // write whatever the query would read that is still unknown, then query
  task automatic query_prepared(int x, int y, int z);
    int  nx, ny, nz;
    bit  in_chunk;
    if (!mirror.voxel_known[mirror.cell_of(x, y, z)])
      send_item(vfc_pkg::CMD_WR_VOXEL, x, y, z, $urandom_range(0, 7), pick_id());
    for (int f = 0; f < vfc_pkg::FACES; f++) begin
      in_chunk = mirror.step_to(f, x, y, z, nx, ny, nz);
      if (in_chunk) begin
        if (!mirror.voxel_known[mirror.cell_of(nx, ny, nz)])
          send_item(vfc_pkg::CMD_WR_VOXEL, nx, ny, nz, $urandom_range(0, 7), pick_id());
      end else if (!mirror.border_known[mirror.slot_of(f, x, y, z)]) begin
        send_item(vfc_pkg::CMD_WR_BOUND, x, y, z, f, pick_id());
      end
    end
    send_item(vfc_pkg::CMD_QUERY, x, y, z, $urandom_range(0, 7),
              vfc_pkg::VID_W'($urandom_range(0, 65535)));
  endtask

  // one random step of the mixed traffic
  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      send_item(vfc_pkg::CMD_WR_VOXEL, pick_coord(), pick_coord(), pick_coord(),
                $urandom_range(0, 7), pick_id());
    else if (r < 55)
      send_item(vfc_pkg::CMD_WR_BOUND, pick_coord(), pick_coord(), pick_coord(),
                $urandom_range(0, vfc_pkg::FACES - 1), pick_id());
    else if (r < 94)
      query_prepared(pick_coord(), pick_coord(), pick_coord());
    else if (r < 97)
      send_item(vfc_pkg::CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 15), $urandom_range(0, 7), pick_id());
    else
      send_item(vfc_pkg::CMD_WR_BOUND, pick_coord(), pick_coord(), pick_coord(),
                $urandom_range(vfc_pkg::FACES, 7), pick_id());
  endtask

  // stop requests and wait until every query answer is back and writes drained
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_present(logic [vfc_pkg::FACES-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    mirror.present = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result side: random pop stalls, check each accepted result
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0)
        rush_out = !rush_out;
      gap = rush_out ? 0 : $urandom_range(0, 11);
      @(negedge clk_i);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      mirror.compare_result(block_id_o, face_mask_o, visible_o);
    end
  end

  // reset, directed requests, random phases, final verdict
  initial begin
    logic [vfc_pkg::FACES-1:0] plan [4];
    int                        start;
    mirror      = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    push        = 1'b0;
    pop         = 1'b0;
    command_i   = vfc_pkg::CMD_WR_VOXEL;
    pos_x_i     = '0;
    pos_y_i     = '0;
    pos_z_i     = '0;
    face_sel_i  = '0;
    voxel_id_i  = '0;
    plan[0] = 6'h3F;
    plan[1] = 6'h00;
    plan[2] = 6'h15;
    plan[3] = 6'h2A;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // corners with every neighbour chunk present
    set_present(6'h3F);
    send_item(vfc_pkg::CMD_WR_VOXEL, 0, 0, 0, 0, 16'hFFFF);
    query_prepared(0, 0, 0);
    send_item(vfc_pkg::CMD_WR_VOXEL, CHUNK_EDGE - 1, CHUNK_EDGE - 1, CHUNK_EDGE - 1, 7,
              16'h0001);
    query_prepared(CHUNK_EDGE - 1, CHUNK_EDGE - 1, CHUNK_EDGE - 1);
    // air voxel still gets a face mask
    send_item(vfc_pkg::CMD_WR_VOXEL, 0, 0, 0, 0, 16'h0000);
    send_item(vfc_pkg::CMD_QUERY, 0, 0, 0, 0, 16'h0000);
    // unused command and face selectors without meaning are ignored
    send_item(vfc_pkg::CMD_NONE, 15, 15, 15, 7, 16'hFFFF);
    send_item(vfc_pkg::CMD_WR_BOUND, 15, 15, 15, 7, 16'hFFFF);
    send_item(vfc_pkg::CMD_WR_BOUND, 0, 0, 0, 6, 16'h0000);
    send_item(vfc_pkg::CMD_QUERY, 15, 15, 15, 7, 16'hFFFF);
    // no neighbour chunks: chunk walls count as air
    settle();
    set_present(6'h00);
    send_item(vfc_pkg::CMD_QUERY, 15, 15, 15, 0, 16'h0000);
    send_item(vfc_pkg::CMD_QUERY, 0, 0, 0, 0, 16'h0000);

    // random traffic under several neighbour settings
    for (int p = 0; p < 6; p++) begin
      settle();
      set_present(p < 4 ? plan[p] : vfc_pkg::FACES'($urandom_range(0, 63)));
      start = counted;
      while (counted - start < PHASE_ITEMS)
        random_step();
    end

    settle();
    if (mirror.outstanding() == 0 && mirror.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
